### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define FAU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define FAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/fau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Floating-point unit package
// Operation and format codes, operand kinds, sequencer states and the
// unpacked operand type used by the floating-point unit.
// ----------------------------------------------------------------------------
package fau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] FMT_B64 = 2'd0;
  localparam logic [1:0] FMT_B32 = 2'd1;
  localparam logic [1:0] FMT_B21 = 2'd2;

  localparam logic [63:0] EMASK_B64 = 64'h7FF0000000000000;
  localparam logic [63:0] EMASK_B32 = 64'h000000007F800000;
  localparam logic [63:0] EMASK_B21 = 64'h00000000000FC000;
  localparam logic [63:0] TOP_BIT   = 64'h8000000000000000;

  localparam int ExpW = 14;

  typedef enum logic [1:0] {
    K_FIN,
    K_INF,
    K_QNAN,
    K_SNAN
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_A,
    ST_NORM_B,
    ST_DISPATCH,
    ST_ALIGN,
    ST_ADD,
    ST_MUL,
    ST_DIV,
    ST_NORM_R,
    ST_PACK
  } state_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    sign;
    logic signed [ExpW-1:0]  exp;
    logic [63:0]             mant;
  } operand_t;

endpackage

`default_nettype wire

### rtl/core/fau_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Floating-point unit command channel
// Valid/ready channel carrying the operation, format and both operands.
// ----------------------------------------------------------------------------
interface fau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [1:0]  fmt;
  logic [63:0] operand_a;
  logic [63:0] operand_b;

  modport source(output valid, op, fmt, operand_a, operand_b, input ready);
  modport sink(input valid, op, fmt, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

### rtl/core/fau_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Floating-point unit result channel
// Valid/ready channel carrying the packed result, compare order and flags.
// ----------------------------------------------------------------------------
interface fau_out_if;
  logic              valid;
  logic              ready;
  logic [63:0]       packed_result;
  logic signed [1:0] order;
  logic              flag_operand;
  logic              flag_inexact;
  logic              flag_overflow;
  logic              flag_underflow;
  logic              flag_div_zero;

  modport source(output valid, packed_result, order, flag_operand, flag_inexact,
                 flag_overflow, flag_underflow, flag_div_zero, input ready);
  modport sink(input valid, packed_result, order, flag_operand, flag_inexact,
               flag_overflow, flag_underflow, flag_div_zero, output ready);
endinterface

`default_nettype wire

### rtl/core/float_add_sub_mul_div_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Floating-point add, subtract, multiply, divide and compare unit
// Truncating arithmetic on binary64, binary32 and a 21-bit layout.
// ----------------------------------------------------------------------------
// Usage: a word on cmd carries op, fmt and two packed operands. It is taken
// when cmd.valid and cmd.ready are both high; cmd.ready is high only while
// the sequencer is idle, so one word is worked on at a time.
// One word gives one word on res: packed result, compare order and flags.
// Special operands go from dispatch straight to the pack step; add, subtract
// and compare pass align, add and result normalisation; multiply and divide
// run their loop, then result normalisation. Denormal operands and cancelling
// sums add normalisation steps. Divide is a 64-step restoring loop on one
// shared subtractor; multiply uses one 32 x 32 multiplier over four partial
// products; leading-zero normalisation shifts by eight or one bit per cycle.
// The result sits in an output register, so a new word is accepted while
// the previous result waits; if the receiver stalls with a result pending,
// the next result waits in the pack step until the register is free.
// Reset is synchronous and returns the sequencer to idle with res empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module float_add_sub_mul_div_unit (
  input  wire      clk,
  input  wire      rst,
  fau_in_if.sink   cmd,
  fau_out_if.source res
);
  import fau_pkg::*;

  state_t   state, state_next;
  logic [2:0] op_r;
  logic [1:0] fmt_r;
  operand_t a, b, r;
  logic [5:0] cnt;
  logic [63:0] prod, hi;
  logic [33:0] mid;
  logic fl_op, fl_inex, fl_dz;

  logic              out_valid;
  logic [63:0]       out_result;
  logic signed [1:0] out_order;
  logic              out_fop, out_finex, out_fovf, out_funf, out_fdz;

  function automatic operand_t unpack(input logic [63:0] w, input logic [1:0] fmt);
    operand_t            u;
    logic                s;
    logic [10:0]         e;
    logic                emax;
    logic [63:0]         fal;
    logic signed [13:0]  half;
    case (fmt)
      FMT_B32: begin
        s = w[31]; e = {3'b0, w[30:23]}; emax = &w[30:23];
        fal = {w[22:0], 41'b0}; half = 14'sd128;
      end
      FMT_B21: begin
        s = w[20]; e = {5'b0, w[19:14]}; emax = &w[19:14];
        fal = {w[13:0], 50'b0}; half = 14'sd32;
      end
      default: begin
        s = w[63]; e = w[62:52]; emax = &w[62:52];
        fal = {w[51:0], 12'b0}; half = 14'sd1024;
      end
    endcase
    u.kind = K_FIN; u.sign = s; u.exp = '0; u.mant = '0;
    if (e == 11'd0 && fal == 64'd0) begin
      u.sign = 1'b0;
    end else if (e == 11'd0) begin
      u.exp = 14'sd2 - half; u.mant = fal;
    end else if (!emax) begin
      u.exp = $signed({3'b0, e}) - (half - 14'sd2);
      u.mant = TOP_BIT | (fal >> 1);
    end else if (fal == 64'd0) begin
      u.kind = K_INF;
    end else if (fal[63]) begin
      u.kind = K_QNAN; u.mant = fal;
    end else begin
      u.kind = K_SNAN; u.mant = fal;
    end
    return u;
  endfunction

  // Shared normaliser.
  logic [63:0]        n_mant_in, n_mant;
  logic signed [13:0] n_exp_in, n_exp;
  kind_t              n_kind;
  logic               n_done;

  always_comb begin
    case (state)
      ST_NORM_A: begin n_mant_in = a.mant; n_exp_in = a.exp; n_kind = a.kind; end
      ST_NORM_B: begin n_mant_in = b.mant; n_exp_in = b.exp; n_kind = b.kind; end
      default:   begin n_mant_in = r.mant; n_exp_in = r.exp; n_kind = r.kind; end
    endcase
    n_done = (n_kind != K_FIN) || n_mant_in[63] || (n_mant_in == 64'd0);
    if (n_mant_in[63:56] == 8'd0) begin
      n_mant = n_mant_in << 8; n_exp = n_exp_in - 14'sd8;
    end else begin
      n_mant = n_mant_in << 1; n_exp = n_exp_in - 14'sd1;
    end
  end

  // Special-case selection.
  logic     a_zero, b_zero, b_seff, is_addlike, s_xor;
  operand_t d, dflt, b_eff;
  state_t   d_next;
  logic     d_fop, d_fdz;

  always_comb begin
    a_zero = (a.kind == K_FIN) && (a.mant == 64'd0);
    b_zero = (b.kind == K_FIN) && (b.mant == 64'd0);
    is_addlike = (op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_CMP);
    b_seff = ((op_r == OP_SUB || op_r == OP_CMP) && !b_zero) ? ~b.sign : b.sign;
    b_eff = b; b_eff.sign = b_seff;
    s_xor = a.sign ^ b.sign;
    dflt.kind = K_QNAN; dflt.sign = 1'b0; dflt.exp = '0; dflt.mant = TOP_BIT;
    d.kind = K_FIN; d.sign = 1'b0; d.exp = '0; d.mant = '0;
    d_next = ST_PACK; d_fop = 1'b0; d_fdz = 1'b0;
    if (op_r > OP_CMP) begin
      d_next = ST_PACK;
    end else if (a.kind == K_SNAN) begin
      d = a; d_fop = 1'b1;
    end else if (b.kind == K_SNAN) begin
      d = b; d_fop = 1'b1;
    end else if (a.kind == K_QNAN) begin
      d = a;
    end else if (b.kind == K_QNAN) begin
      d = b;
    end else if (is_addlike) begin
      if (a.kind == K_INF) begin
        if (b.kind == K_INF) d = (a.sign == b_seff) ? a : dflt;
        else d = a;
      end else if (b.kind == K_INF || a_zero) begin
        d = b_eff;
      end else if (b_zero) begin
        d = a;
      end else begin
        d_next = ST_ALIGN;
      end
    end else if (op_r == OP_MUL) begin
      if (a.kind == K_INF && b.kind == K_INF) begin
        d = (a.sign == b.sign) ? a : dflt;
      end else if (a.kind == K_INF || b.kind == K_INF) begin
        d.kind = K_INF; d.sign = s_xor;
      end else if (a_zero || b_zero) begin
        d_next = ST_PACK;
      end else begin
        d.sign = s_xor; d.exp = a.exp + b.exp; d_next = ST_MUL;
      end
    end else begin
      if (a.kind == K_INF) begin
        if (b.kind == K_INF) begin
          d = dflt;
        end else if (b_zero) begin
          d = a; d_fdz = 1'b1;
        end else begin
          d.kind = K_INF; d.sign = s_xor;
        end
      end else if (b.kind == K_INF || a_zero) begin
        d_next = ST_PACK;
      end else if (b_zero) begin
        d_fdz = 1'b1;
      end else begin
        d.sign = s_xor; d.exp = a.exp - b.exp + 14'sd1; d_next = ST_DIV;
      end
    end
  end

  // Exponent alignment.
  logic signed [13:0] al_diff, al_amt;
  logic [63:0]        al_src, al_shifted, al_mask;
  logic               al_big, al_inex;

  always_comb begin
    al_diff = a.exp - b.exp;
    al_src  = (al_diff < 14'sd0) ? a.mant : b.mant;
    al_amt  = (al_diff < 14'sd0) ? -al_diff : al_diff;
    al_big  = al_amt >= 14'sd64;
    al_mask = (64'd1 << al_amt[5:0]) - 64'd1;
    if (al_big) begin
      al_shifted = 64'd0; al_inex = (al_src != 64'd0);
    end else begin
      al_shifted = al_src >> al_amt[5:0]; al_inex = |(al_src & al_mask);
    end
  end

  // Add or subtract of aligned mantissas.
  logic [64:0]        sum65;
  logic [63:0]        ad_mant;
  logic signed [13:0] ad_exp;
  logic               ad_sign, ad_inex;

  always_comb begin
    sum65 = {1'b0, a.mant} + {1'b0, b.mant};
    ad_inex = 1'b0; ad_exp = a.exp; ad_sign = a.sign;
    if (a.sign == b.sign) begin
      if (sum65[64]) begin
        ad_mant = {1'b1, sum65[63:1]}; ad_exp = a.exp + 14'sd1; ad_inex = sum65[0];
      end else begin
        ad_mant = sum65[63:0];
      end
    end else if (a.mant >= b.mant) begin
      ad_mant = a.mant - b.mant;
    end else begin
      ad_mant = b.mant - a.mant; ad_sign = b.sign;
    end
  end

  // Multiplier operand selection and divider step.
  logic [31:0] mul_a, mul_b;
  logic        dv_ge;
  logic [63:0] dv_rem;

  always_comb begin
    mul_a = cnt[1] ? a.mant[63:32] : a.mant[31:0];
    mul_b = cnt[0] ? b.mant[63:32] : b.mant[31:0];
    dv_ge = a.mant >= b.mant;
    dv_rem = dv_ge ? a.mant - b.mant : a.mant;
  end

  // Packing.
  logic [6:0]         fb;
  logic signed [13:0] half, emin, fb14, be, dsh;
  logic [63:0]        emask, fmask, qbit, sbit, nanfrac, lowmask, dmask;
  logic [5:0]         spos;
  logic [63:0]        p_val;
  logic               p_inex, p_ovf, p_unf;
  logic signed [1:0]  p_order;
  logic               out_free;

  always_comb begin
    case (fmt_r)
      FMT_B32: begin fb = 7'd23; half = 14'sd128; emask = EMASK_B32; spos = 6'd31; end
      FMT_B21: begin fb = 7'd14; half = 14'sd32; emask = EMASK_B21; spos = 6'd20; end
      default: begin fb = 7'd52; half = 14'sd1024; emask = EMASK_B64; spos = 6'd63; end
    endcase
    fb14    = $signed({7'b0, fb});
    emin    = 14'sd3 - half;
    fmask   = (64'd1 << fb) - 64'd1;
    qbit    = 64'd1 << (fb - 7'd1);
    sbit    = {63'b0, r.sign} << spos;
    nanfrac = (r.mant >> (7'd64 - fb)) & fmask;
    be      = r.exp + half - 14'sd2;
    lowmask = (64'd1 << (7'd63 - fb)) - 64'd1;
    dsh     = 14'sd64 - fb14 + emin - 14'sd1 - r.exp;
    dmask   = (64'd1 << dsh[5:0]) - 64'd1;
    p_val = 64'd0; p_inex = 1'b0; p_ovf = 1'b0; p_unf = 1'b0; p_order = 2'sd0;
    if (op_r == OP_CMP) begin
      if (r.kind == K_INF || (r.kind == K_FIN && r.mant != 64'd0))
        p_order = r.sign ? -2'sd1 : 2'sd1;
    end else if (op_r < OP_CMP) begin
      case (r.kind)
        K_SNAN: p_val = sbit | emask | (nanfrac & ~qbit);
        K_QNAN: p_val = sbit | emask | nanfrac | qbit;
        K_INF:  p_val = sbit | emask;
        default: begin
          if (r.mant == 64'd0) begin
            p_val = 64'd0;
          end else if (r.exp > half) begin
            p_ovf = 1'b1; p_val = sbit | emask;
          end else if (r.exp >= emin) begin
            p_inex = |(r.mant & lowmask);
            p_val = sbit | ({50'b0, be} << fb) | ((r.mant >> (7'd63 - fb)) & fmask);
          end else if (dsh <= 14'sd63) begin
            p_inex = |(r.mant & dmask);
            p_val = sbit | ((r.mant >> dsh[5:0]) & fmask);
          end else begin
            p_unf = 1'b1;
          end
        end
      endcase
    end
  end

  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (cmd.valid) state_next = ST_NORM_A;
      ST_NORM_A:   if (n_done) state_next = ST_NORM_B;
      ST_NORM_B:   if (n_done) state_next = ST_DISPATCH;
      ST_DISPATCH: state_next = d_next;
      ST_ALIGN:    state_next = ST_ADD;
      ST_ADD:      state_next = ST_NORM_R;
      ST_MUL:      if (cnt == 6'd4) state_next = ST_NORM_R;
      ST_DIV:      if (cnt == 6'd63) state_next = ST_NORM_R;
      ST_NORM_R:   if (n_done) state_next = ST_PACK;
      ST_PACK:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  assign cmd.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (cmd.valid) begin
        op_r <= cmd.op; fmt_r <= cmd.fmt;
        a <= unpack(cmd.operand_a, cmd.fmt);
        b <= unpack(cmd.operand_b, cmd.fmt);
        fl_inex <= 1'b0;
      end
      ST_NORM_A: if (!n_done) begin a.mant <= n_mant; a.exp <= n_exp; end
      ST_NORM_B: if (!n_done) begin b.mant <= n_mant; b.exp <= n_exp; end
      ST_DISPATCH: begin
        r <= d; fl_op <= d_fop; fl_dz <= d_fdz;
        if (is_addlike) b.sign <= b_seff;
        cnt <= 6'd0; mid <= 34'd0; hi <= 64'd0;
      end
      ST_ALIGN: begin
        if (al_diff < 14'sd0) begin
          a.mant <= al_shifted; a.exp <= b.exp;
        end else begin
          b.mant <= al_shifted;
        end
        if (al_inex) fl_inex <= 1'b1;
      end
      ST_ADD: begin
        r.kind <= K_FIN; r.mant <= ad_mant; r.exp <= ad_exp; r.sign <= ad_sign;
        if (ad_inex) fl_inex <= 1'b1;
      end
      ST_MUL: begin
        prod <= {32'b0, mul_a} * {32'b0, mul_b};
        cnt <= cnt + 6'd1;
        case (cnt)
          6'd1: mid <= {2'b0, prod[63:32]};
          6'd2, 6'd3: begin
            mid <= mid + {2'b0, prod[31:0]};
            hi  <= hi + {32'b0, prod[63:32]};
          end
          6'd4: r.mant <= hi + prod + {62'b0, mid[33:32]};
          default: ;
        endcase
      end
      ST_DIV: begin
        r.mant <= {r.mant[62:0], dv_ge};
        if (cnt == 6'd0) begin
          a.mant <= dv_rem; b.mant <= b.mant >> 1;
        end else begin
          a.mant <= dv_rem << 1;
        end
        cnt <= cnt + 6'd1;
      end
      ST_NORM_R: if (!n_done) begin r.mant <= n_mant; r.exp <= n_exp; end
      ST_PACK: if (out_free) begin
        out_result <= p_val; out_order <= p_order;
        out_fop <= fl_op; out_finex <= fl_inex | p_inex;
        out_fovf <= p_ovf; out_funf <= p_unf; out_fdz <= fl_dz;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PACK && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid          = out_valid;
  assign res.packed_result  = out_result;
  assign res.order          = out_order;
  assign res.flag_operand   = out_fop;
  assign res.flag_inexact   = out_finex;
  assign res.flag_overflow  = out_fovf;
  assign res.flag_underflow = out_funf;
  assign res.flag_div_zero  = out_fdz;

  `FAU_ASSERT(a_busy_after_accept, clk, rst, (cmd.valid && cmd.ready) |=> !cmd.ready, "accepted word did not leave idle")
  `FAU_ASSERT(a_pack_holds, clk, rst, (state == ST_PACK && out_valid && !res.ready) |=> (state == ST_PACK), "result overwrote a pending word")
  `FAU_ASSERT(a_div_ends, clk, rst, (state == ST_DIV && cnt == 6'd63) |=> (state == ST_NORM_R), "divide loop ran past 64 steps")

endmodule

`default_nettype wire
